// ----- hdl/sandpile_topple_engine_macros.svh -----
// Assertion helpers for the sandpile topple engine.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SANDPILE_TOPPLE_ENGINE_MACROS_SVH
`define SANDPILE_TOPPLE_ENGINE_MACROS_SVH

`define SPTE_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spte: same-cycle implication violated");

`define SPTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spte: next-cycle implication violated");

`define SPTE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("spte: forbidden condition seen");

`endif

// ----- hdl/spte_pkg.sv -----
`default_nettype none
package spte_pkg;

  localparam int GRID_SIDE_DEF  = 32;
  localparam int FIFO_DEPTH_DEF = 1024;

  localparam int CMD_W       = 2;
  localparam int COORD_W     = 5;
  localparam int HEIGHT_IN_W = 4;
  localparam int HEIGHT_W    = 8;
  localparam int STATUS_W    = 2;
  localparam int TOPPLE_W    = 16;

  localparam int HEIGHT_MAX  = 255;
  localparam int TOPPLE_LOSS = 8;
  localparam int TOPPLE_MOD  = 9;
  localparam int MULT_LAST   = HEIGHT_MAX / TOPPLE_MOD;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DROP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Neighbor order: left column (up, same, down), same column (up, down),
  // right column (up, same, down).
  localparam logic [7:0] NB_DR_NEG = 8'b0010_1001;
  localparam logic [7:0] NB_DR_POS = 8'b1001_0100;
  localparam logic [7:0] NB_DC_NEG = 8'b0000_0111;
  localparam logic [7:0] NB_DC_POS = 8'b1110_0000;
  localparam logic [2:0] NB_LAST   = 3'd7;

  typedef struct packed {
    logic                sink;
    logic [HEIGHT_W-1:0] height;
  } cell_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_DROP_WAIT,
    S_POP,
    S_POP_WAIT,
    S_TOP,
    S_NB,
    S_DONE
  } state_e;

  function automatic logic is_mult9(input logic [HEIGHT_W-1:0] h);
    logic hit;
    hit = 1'b0;
    for (int k = 1; k <= MULT_LAST; k++) begin
      if (h == HEIGHT_W'(TOPPLE_MOD * k)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [HEIGHT_W-1:0] topple_sub(input logic [HEIGHT_W-1:0] h);
    return (h >= HEIGHT_W'(TOPPLE_LOSS)) ? h - HEIGHT_W'(TOPPLE_LOSS) : '0;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/spte_ifs.sv -----
`default_nettype none
interface spte_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [spte_pkg::CMD_W-1:0]         cmd;
  logic [spte_pkg::COORD_W-1:0]       row;
  logic [spte_pkg::COORD_W-1:0]       col;
  logic [spte_pkg::HEIGHT_IN_W-1:0]   height;
  logic                               make_sink;

  modport source (output valid, cmd, row, col, height, make_sink, input ready);
  modport sink   (input valid, cmd, row, col, height, make_sink, output ready);
endinterface

interface spte_res_if;
  logic                            valid;
  logic                            ready;
  logic [spte_pkg::STATUS_W-1:0]   status;
  logic [spte_pkg::HEIGHT_W-1:0]   cell_height;
  logic                            cell_is_sink;
  logic [spte_pkg::TOPPLE_W-1:0]   topple_count;

  modport source (output valid, status, cell_height, cell_is_sink, topple_count, input ready);
  modport sink   (input valid, status, cell_height, cell_is_sink, topple_count, output ready);
endinterface
`default_nettype wire

// ----- hdl/spte_grid_ram.sv -----
`default_nettype none
module spte_grid_ram #(
  parameter int  CELLS  = spte_pkg::GRID_SIDE_DEF * spte_pkg::GRID_SIDE_DEF,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  spte_pkg::cell_t       wdata_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output spte_pkg::cell_t       rdata_o
);

  spte_pkg::cell_t mem_q [CELLS];
  spte_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/spte_fifo.sv -----
`default_nettype none
module spte_fifo #(
  parameter int  DEPTH  = spte_pkg::FIFO_DEPTH_DEF,
  parameter int  DATA_W = 10,
  localparam int PTR_W  = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spte_pkg::fifo_ctl_t   ctl_i,
  input  logic [DATA_W-1:0]     wdata_i,
  output logic [DATA_W-1:0]     rdata_o,
  output spte_pkg::fifo_sts_t   sts_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push_ok;
  logic              pop_ok;

  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CNT_W'(DEPTH));
  assign push_ok     = ctl_i.push && !sts_o.full;
  assign pop_ok      = ctl_i.pop && !sts_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(push_ok) - CNT_W'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
    if (pop_ok) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/spte_ctrl.sv -----
`default_nettype none
module spte_ctrl #(
  parameter int  GRID_SIDE = spte_pkg::GRID_SIDE_DEF,
  localparam int CELLS     = GRID_SIDE * GRID_SIDE,
  localparam int CELL_W    = $clog2(CELLS),
  localparam int RC_W      = $clog2(GRID_SIDE),
  localparam int ENTRY_W   = 2 * RC_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  spte_cmd_if.sink               cmd_i,
  spte_res_if.source             res_o,
  output logic                   grid_we_o,
  output logic [CELL_W-1:0]      grid_waddr_o,
  output spte_pkg::cell_t        grid_wdata_o,
  output logic [CELL_W-1:0]      grid_raddr_o,
  input  spte_pkg::cell_t        grid_rdata_i,
  output spte_pkg::fifo_ctl_t    fifo_ctl_o,
  output logic [ENTRY_W-1:0]     fifo_wdata_o,
  input  logic [ENTRY_W-1:0]     fifo_rdata_i,
  input  spte_pkg::fifo_sts_t    fifo_sts_i
);

  localparam logic [RC_W-1:0] CENTRE = RC_W'(GRID_SIDE / 2);
  localparam logic [RC_W-1:0] EDGE   = RC_W'(GRID_SIDE - 1);

  function automatic logic [RC_W-1:0] step(input logic [RC_W-1:0] v,
                                           input logic neg, input logic pos);
    return neg ? v - 1'b1 : (pos ? v + 1'b1 : v);
  endfunction

  function automatic logic nb_ok(input logic [2:0] k, input logic [RC_W-1:0] r,
                                 input logic [RC_W-1:0] c);
    return !(spte_pkg::NB_DC_NEG[k] && c == '0) && !(spte_pkg::NB_DC_POS[k] && c == EDGE) &&
           !(spte_pkg::NB_DR_NEG[k] && r == '0) && !(spte_pkg::NB_DR_POS[k] && r == EDGE);
  endfunction

  function automatic logic [CELL_W-1:0] lin(input logic [RC_W-1:0] r,
                                            input logic [RC_W-1:0] c);
    return CELL_W'(int'(r) * GRID_SIDE + int'(c));
  endfunction

  spte_pkg::state_e state_q, state_d;
  logic [CELL_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              out_valid_q, out_valid_d;

  logic [RC_W-1:0]   cur_row_q, cur_row_d;
  logic [RC_W-1:0]   cur_col_q, cur_col_d;
  logic [2:0]        nb_k_q, nb_k_d;
  logic [spte_pkg::TOPPLE_W-1:0] topples_q, topples_d;
  logic              ovf_q, ovf_d;
  logic [spte_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [spte_pkg::HEIGHT_W-1:0] res_height_q, res_height_d;
  logic              res_sink_q, res_sink_d;

  logic [spte_pkg::STATUS_W-1:0] out_status_q;
  logic [spte_pkg::HEIGHT_W-1:0] out_height_q;
  logic              out_sink_q;
  logic [spte_pkg::TOPPLE_W-1:0] out_topples_q;
  logic              out_load;

  logic              in_fire;
  logic              in_inside;
  logic [CELL_W-1:0] in_addr;

  logic [RC_W-1:0]   tgt_row, tgt_col;
  logic              tgt_ok;
  logic [spte_pkg::HEIGHT_W-1:0] grain_h;
  logic              grain_do;

  logic [2:0]        nxt_k;
  logic [RC_W-1:0]   nxt_row, nxt_col;
  logic [CELL_W-1:0] nxt_addr;

  logic [RC_W-1:0]   pop_row, pop_col;

  assign cmd_i.ready = (state_q == spte_pkg::S_IDLE);
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign in_inside   = (int'(cmd_i.row) < GRID_SIDE) && (int'(cmd_i.col) < GRID_SIDE);
  assign in_addr     = CELL_W'(int'(cmd_i.row) * GRID_SIDE + int'(cmd_i.col));

  assign tgt_row  = (state_q == spte_pkg::S_NB) ?
                    step(cur_row_q, spte_pkg::NB_DR_NEG[nb_k_q], spte_pkg::NB_DR_POS[nb_k_q]) :
                    cur_row_q;
  assign tgt_col  = (state_q == spte_pkg::S_NB) ?
                    step(cur_col_q, spte_pkg::NB_DC_NEG[nb_k_q], spte_pkg::NB_DC_POS[nb_k_q]) :
                    cur_col_q;
  assign tgt_ok   = (state_q == spte_pkg::S_NB) ? nb_ok(nb_k_q, cur_row_q, cur_col_q) : 1'b1;
  assign grain_h  = grid_rdata_i.height + 1'b1;
  assign grain_do = tgt_ok && !grid_rdata_i.sink &&
                    (grid_rdata_i.height != spte_pkg::HEIGHT_W'(spte_pkg::HEIGHT_MAX));

  assign nxt_k    = (state_q == spte_pkg::S_TOP) ? '0 : nb_k_q + 1'b1;
  assign nxt_row  = step(cur_row_q, spte_pkg::NB_DR_NEG[nxt_k], spte_pkg::NB_DR_POS[nxt_k]);
  assign nxt_col  = step(cur_col_q, spte_pkg::NB_DC_NEG[nxt_k], spte_pkg::NB_DC_POS[nxt_k]);
  assign nxt_addr = nb_ok(nxt_k, cur_row_q, cur_col_q) ? lin(nxt_row, nxt_col) : '0;

  assign pop_row  = fifo_rdata_i[ENTRY_W-1:RC_W];
  assign pop_col  = fifo_rdata_i[RC_W-1:0];

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    nb_k_d       = nb_k_q;
    topples_d    = topples_q;
    ovf_d        = ovf_q;
    res_status_d = res_status_q;
    res_height_d = res_height_q;
    res_sink_d   = res_sink_q;
    out_load     = 1'b0;
    grid_we_o    = 1'b0;
    grid_waddr_o = '0;
    grid_wdata_o = '0;
    grid_raddr_o = '0;
    fifo_ctl_o   = '0;
    fifo_wdata_o = {tgt_row, tgt_col};

    case (state_q)
      spte_pkg::S_CLEAR: begin
        grid_we_o    = 1'b1;
        grid_waddr_o = clr_cnt_q;
        clr_cnt_d    = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CELL_W'(CELLS - 1)) begin
          state_d = spte_pkg::S_IDLE;
        end
      end
      spte_pkg::S_IDLE: begin
        if (in_fire) begin
          res_status_d = spte_pkg::STATUS_OK;
          res_height_d = '0;
          res_sink_d   = 1'b0;
          topples_d    = '0;
          ovf_d        = 1'b0;
          cur_row_d    = CENTRE;
          cur_col_d    = CENTRE;
          state_d      = spte_pkg::S_DONE;
          case (cmd_i.cmd)
            spte_pkg::CMD_WRITE: begin
              if (in_inside) begin
                grid_we_o           = 1'b1;
                grid_waddr_o        = in_addr;
                grid_wdata_o.sink   = cmd_i.make_sink;
                grid_wdata_o.height = cmd_i.make_sink ? '0 :
                                      spte_pkg::HEIGHT_W'(cmd_i.height);
              end
            end
            spte_pkg::CMD_READ: begin
              if (in_inside) begin
                grid_raddr_o = in_addr;
                state_d      = spte_pkg::S_RD_WAIT;
              end
            end
            spte_pkg::CMD_DROP: begin
              grid_raddr_o = lin(CENTRE, CENTRE);
              state_d      = spte_pkg::S_DROP_WAIT;
            end
            default: begin
              state_d = spte_pkg::S_DONE;
            end
          endcase
        end
      end
      spte_pkg::S_RD_WAIT: begin
        res_height_d = grid_rdata_i.height;
        res_sink_d   = grid_rdata_i.sink;
        state_d      = spte_pkg::S_DONE;
      end
      spte_pkg::S_DROP_WAIT, spte_pkg::S_NB: begin
        if (state_q == spte_pkg::S_DROP_WAIT && grid_rdata_i.sink) begin
          res_status_d = spte_pkg::STATUS_REFUSED;
          state_d      = spte_pkg::S_DONE;
        end else begin
          if (grain_do) begin
            grid_we_o           = 1'b1;
            grid_waddr_o        = lin(tgt_row, tgt_col);
            grid_wdata_o.height = grain_h;
            if (spte_pkg::is_mult9(grain_h)) begin
              if (fifo_sts_i.full) begin
                ovf_d = 1'b1;
              end else begin
                fifo_ctl_o.push = 1'b1;
              end
            end
          end
          if (state_q == spte_pkg::S_NB && nb_k_q != spte_pkg::NB_LAST) begin
            nb_k_d       = nxt_k;
            grid_raddr_o = nxt_addr;
          end else begin
            state_d = spte_pkg::S_POP;
          end
        end
      end
      spte_pkg::S_POP: begin
        if (fifo_sts_i.empty) begin
          res_status_d = ovf_q ? spte_pkg::STATUS_OVERFLOW : spte_pkg::STATUS_OK;
          state_d      = spte_pkg::S_DONE;
        end else begin
          fifo_ctl_o.pop = 1'b1;
          state_d        = spte_pkg::S_POP_WAIT;
        end
      end
      spte_pkg::S_POP_WAIT: begin
        cur_row_d    = pop_row;
        cur_col_d    = pop_col;
        grid_raddr_o = lin(pop_row, pop_col);
        state_d      = spte_pkg::S_TOP;
      end
      spte_pkg::S_TOP: begin
        grid_we_o           = 1'b1;
        grid_waddr_o        = lin(cur_row_q, cur_col_q);
        grid_wdata_o.sink   = grid_rdata_i.sink;
        grid_wdata_o.height = spte_pkg::topple_sub(grid_rdata_i.height);
        if (topples_q != '1) begin
          topples_d = topples_q + 1'b1;
        end
        nb_k_d       = nxt_k;
        grid_raddr_o = nxt_addr;
        state_d      = spte_pkg::S_NB;
      end
      spte_pkg::S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_load = 1'b1;
          state_d  = spte_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spte_pkg::S_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && !res_o.ready) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spte_pkg::S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_row_q    <= cur_row_d;
    cur_col_q    <= cur_col_d;
    nb_k_q       <= nb_k_d;
    topples_q    <= topples_d;
    ovf_q        <= ovf_d;
    res_status_q <= res_status_d;
    res_height_q <= res_height_d;
    res_sink_q   <= res_sink_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_height_q  <= res_height_q;
      out_sink_q    <= res_sink_q;
      out_topples_q <= topples_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_status_q;
  assign res_o.cell_height  = out_height_q;
  assign res_o.cell_is_sink = out_sink_q;
  assign res_o.topple_count = out_topples_q;

endmodule
`default_nettype wire

// ----- hdl/sandpile_topple_engine.sv -----
// Sandpile topple engine on a GRID_SIDE by GRID_SIDE grid. Every word accepted on cmd_i
// yields exactly one word on res_o: command 0 writes one cell (height, or sink), command 2
// reads one cell, command 1 drops a grain on the center cell and relaxes the whole
// avalanche before answering with its status and toppling count. Grid state lives in one
// synchronous memory and pending topples in a FIFO memory of FIFO_DEPTH entries. After
// reset the block sweeps every grid cell to zero and holds cmd_i.ready low meanwhile. Words
// are taken one at a time; a drop runs its topplings one after another, each a FIFO read,
// a read-modify-write of the popped cell and eight pipelined read-modify-writes of its
// neighbors through the grid memory's single read and write port. A finished word waits
// in an output register, so the next command is accepted while it is still unread.
`default_nettype none
module sandpile_topple_engine #(
  parameter int GRID_SIDE  = spte_pkg::GRID_SIDE_DEF,
  parameter int FIFO_DEPTH = spte_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spte_cmd_if.sink   cmd_i,
  spte_res_if.source res_o
);

  localparam int CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int ENTRY_W = 2 * $clog2(GRID_SIDE);

  logic                  grid_we;
  logic [CELL_W-1:0]     grid_waddr;
  spte_pkg::cell_t       grid_wdata;
  logic [CELL_W-1:0]     grid_raddr;
  spte_pkg::cell_t       grid_rdata;
  spte_pkg::fifo_ctl_t   fifo_ctl;
  spte_pkg::fifo_sts_t   fifo_sts;
  logic [ENTRY_W-1:0]    fifo_wdata;
  logic [ENTRY_W-1:0]    fifo_rdata;

  spte_ctrl #(
    .GRID_SIDE (GRID_SIDE)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .res_o        (res_o),
    .grid_we_o    (grid_we),
    .grid_waddr_o (grid_waddr),
    .grid_wdata_o (grid_wdata),
    .grid_raddr_o (grid_raddr),
    .grid_rdata_i (grid_rdata),
    .fifo_ctl_o   (fifo_ctl),
    .fifo_wdata_o (fifo_wdata),
    .fifo_rdata_i (fifo_rdata),
    .fifo_sts_i   (fifo_sts)
  );

  spte_grid_ram #(
    .CELLS (CELLS)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  spte_fifo #(
    .DEPTH  (FIFO_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fifo_ctl),
    .wdata_i (fifo_wdata),
    .rdata_o (fifo_rdata),
    .sts_o   (fifo_sts)
  );

`include "sandpile_topple_engine_macros.svh"

  `SPTE_ASSERT_IMPLY(a_pop_not_empty, fifo_ctl.pop, !fifo_sts.empty)
  `SPTE_ASSERT_IMPLY(a_accept_fifo_drained, cmd_i.valid && cmd_i.ready, fifo_sts.empty)
  `SPTE_ASSERT_NEXT(a_one_word_in_flight, cmd_i.valid && cmd_i.ready, !cmd_i.ready)
  `SPTE_ASSERT_NEVER(a_push_pop_apart, fifo_ctl.push && fifo_ctl.pop)

endmodule
`default_nettype wire

// ----- tb/sv/sandpile_topple_engine_chk.sv -----
module sandpile_topple_engine_chk (
  input  logic clk_i,
  input  logic rst_ni,
  spte_cmd_if  cmd_i,
  spte_res_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int SIDE        = spte_pkg::GRID_SIDE_DEF;
  localparam int CELLS       = SIDE * SIDE;
  localparam int CENTER      = SIDE / 2;
  localparam int UNSTABLE_MAX = spte_pkg::FIFO_DEPTH_DEF;
  localparam int TOPPLE_SAT  = (1 << spte_pkg::TOPPLE_W) - 1;

  typedef struct packed {
    logic [spte_pkg::STATUS_W-1:0] status;
    logic [spte_pkg::HEIGHT_W-1:0] height;
    logic                          is_sink;
    logic [spte_pkg::TOPPLE_W-1:0] topples;
  } pile_answer_t;

  logic [spte_pkg::HEIGHT_W-1:0] pile_height [CELLS];
  logic                pile_sink   [CELLS];
  int unsigned         unstable_q  [$];
  logic                spilled;
  pile_answer_t        answers_due [$];
  int                  fails;

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      pile_height[i] = '0;
      pile_sink[i]   = 1'b0;
    end
    spilled      = 1'b0;
    fails        = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void add_grain(int r, int c);
    int idx;
    idx = r * SIDE + c;
    if (pile_sink[idx] ||
        pile_height[idx] == spte_pkg::HEIGHT_W'(spte_pkg::HEIGHT_MAX)) begin
      return;
    end
    pile_height[idx] = pile_height[idx] + 1'b1;
    if (int'(pile_height[idx]) % spte_pkg::TOPPLE_MOD == 0) begin
      if (unstable_q.size() >= UNSTABLE_MAX) begin
        spilled = 1'b1;
      end else begin
        unstable_q.push_back(idx);
      end
    end
  endfunction

  function automatic pile_answer_t predict_answer(
    logic [spte_pkg::CMD_W-1:0]       cmd,
    logic [spte_pkg::COORD_W-1:0]     row,
    logic [spte_pkg::COORD_W-1:0]     col,
    logic [spte_pkg::HEIGHT_IN_W-1:0] h,
    logic                             sink
  );
    pile_answer_t ans;
    int           idx;
    int           pop_idx;
    int           pr;
    int           pc;
    int unsigned  topples;
    ans = '0;
    idx = int'(row) * SIDE + int'(col);
    case (cmd)
      spte_pkg::CMD_WRITE: begin
        pile_sink[idx]   = sink;
        pile_height[idx] = sink ? '0 : spte_pkg::HEIGHT_W'(h);
      end
      spte_pkg::CMD_READ: begin
        ans.height  = pile_height[idx];
        ans.is_sink = pile_sink[idx];
      end
      spte_pkg::CMD_DROP: begin
        if (pile_sink[CENTER * SIDE + CENTER]) begin
          ans.status = spte_pkg::STATUS_REFUSED;
        end else begin
          spilled = 1'b0;
          topples = 0;
          add_grain(CENTER, CENTER);
          while (unstable_q.size() > 0) begin
            pop_idx = unstable_q.pop_front();
            pr      = pop_idx / SIDE;
            pc      = pop_idx % SIDE;
            pile_height[pop_idx] =
              (pile_height[pop_idx] >= spte_pkg::HEIGHT_W'(spte_pkg::TOPPLE_LOSS)) ?
              pile_height[pop_idx] - spte_pkg::HEIGHT_W'(spte_pkg::TOPPLE_LOSS) : '0;
            if (topples < TOPPLE_SAT) begin
              topples++;
            end
            // Neighbors go left column first, then same column, then right column.
            for (int dc = -1; dc <= 1; dc++) begin
              for (int dr = -1; dr <= 1; dr++) begin
                if ((dc != 0 || dr != 0) && pc + dc >= 0 && pc + dc < SIDE &&
                    pr + dr >= 0 && pr + dr < SIDE) begin
                  add_grain(pr + dr, pc + dc);
                end
              end
            end
          end
          ans.status  = spilled ? spte_pkg::STATUS_OVERFLOW : spte_pkg::STATUS_OK;
          ans.topples = spte_pkg::TOPPLE_W'(topples);
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    pile_answer_t want;
    if (rst_ni) begin
      if (res_i.valid && res_i.ready) begin
        if (answers_due.size() == 0) begin
          $error("result word arrived with no command outstanding");
          fails++;
        end else begin
          want = answers_due.pop_front();
          compare_field("status", 32'(want.status), 32'(res_i.status));
          compare_field("cell_height", 32'(want.height), 32'(res_i.cell_height));
          compare_field("cell_is_sink", 32'(want.is_sink), 32'(res_i.cell_is_sink));
          compare_field("topple_count", 32'(want.topples), 32'(res_i.topple_count));
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        answers_due.push_back(predict_answer(cmd_i.cmd, cmd_i.row, cmd_i.col,
                                             cmd_i.height, cmd_i.make_sink));
      end
      fail_count_o <= fails;
      pending_o    <= answers_due.size();
    end
  end

endmodule

// ----- tb/sv/sandpile_topple_engine_tb.sv -----
module sandpile_topple_engine_tb;

  localparam logic [spte_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int CENTER       = spte_pkg::GRID_SIDE_DEF / 2;
  localparam int TARGET_WORDS = 140;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT_WORD = 60;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   words_sent;
  int   cmd_run;
  int   res_seen;

  spte_cmd_if cmd_ch ();
  spte_res_if res_ch ();

  sandpile_topple_engine i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_ch),
    .res_o  (res_ch)
  );

  sandpile_topple_engine_chk i_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (cmd_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int near_center(int reach);
    return CENTER - reach + int'($urandom_range(0, 2 * reach));
  endfunction

  task automatic send_word(input logic [spte_pkg::CMD_W-1:0] cmd, input int row,
                           input int col, input int h, input logic sink);
    int gap;
    if (cmd_run > 0) begin
      cmd_run--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 7) == 0) begin
        cmd_run = $urandom_range(4, 12);
      end
    end
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.cmd       <= cmd;
    cmd_ch.row       <= spte_pkg::COORD_W'(row);
    cmd_ch.col       <= spte_pkg::COORD_W'(col);
    cmd_ch.height    <= spte_pkg::HEIGHT_IN_W'(h);
    cmd_ch.make_sink <= sink;
    do @(posedge clk); while (!cmd_ch.ready);
    if (cmd != CMD_UNKNOWN) begin
      words_sent++;
    end
  endtask

  task automatic await_all_answers();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The receiver stalls once for a long stretch so the engine backs up into its input.
  initial begin
    int wait_cycles;
    int run_left;
    res_ch.ready <= 1'b0;
    run_left = 0;
    res_seen = 0;
    wait (rst_n);
    forever begin
      if (res_seen == HOLD_AT_WORD) begin
        wait_cycles = LONG_HOLD;
      end else if (run_left > 0) begin
        run_left--;
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 14);
        if ($urandom_range(0, 7) == 0) begin
          run_left = $urandom_range(4, 12);
        end
      end
      if (wait_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      res_seen++;
    end
  end

  initial begin
    int   reach;
    logic paused;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.cmd       <= spte_pkg::CMD_WRITE;
    cmd_ch.row       <= '0;
    cmd_ch.col       <= '0;
    cmd_ch.height    <= '0;
    cmd_ch.make_sink <= 1'b0;
    words_sent = 0;
    cmd_run    = 0;
    paused     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(spte_pkg::CMD_READ, CENTER, CENTER, 0, 1'b0);
    send_word(spte_pkg::CMD_WRITE, 0, 0, 15, 1'b0);
    send_word(spte_pkg::CMD_READ, 0, 0, 0, 1'b0);
    send_word(spte_pkg::CMD_WRITE, 31, 31, 15, 1'b1);
    send_word(spte_pkg::CMD_READ, 31, 31, 15, 1'b1);
    send_word(CMD_UNKNOWN, 31, 31, 15, 1'b1);
    send_word(spte_pkg::CMD_READ, 31, 0, 0, 1'b0);
    send_word(spte_pkg::CMD_WRITE, CENTER, CENTER, 8, 1'b0);
    send_word(spte_pkg::CMD_DROP, 0, 0, 0, 1'b0);
    send_word(spte_pkg::CMD_READ, CENTER, CENTER, 0, 1'b0);
    send_word(spte_pkg::CMD_READ, CENTER - 1, CENTER + 1, 0, 1'b0);
    send_word(spte_pkg::CMD_WRITE, CENTER, CENTER, 15, 1'b1);
    send_word(spte_pkg::CMD_DROP, 31, 31, 15, 1'b1);
    send_word(spte_pkg::CMD_READ, CENTER, CENTER, 0, 1'b0);
    send_word(spte_pkg::CMD_WRITE, CENTER, CENTER, 8, 1'b0);
    send_word(spte_pkg::CMD_WRITE, CENTER, CENTER + 1, 8, 1'b0);
    send_word(spte_pkg::CMD_WRITE, CENTER + 1, CENTER + 1, 0, 1'b1);
    send_word(spte_pkg::CMD_DROP, 0, 0, 0, 1'b0);
    send_word(spte_pkg::CMD_READ, CENTER + 1, CENTER + 1, 0, 1'b0);
    send_word(spte_pkg::CMD_READ, CENTER, CENTER + 2, 0, 1'b0);
    send_word(spte_pkg::CMD_WRITE, CENTER + 1, CENTER + 1, 0, 1'b0);
    send_word(spte_pkg::CMD_READ, 0, 31, 0, 1'b0);

    while (words_sent < TARGET_WORDS) begin
      if (!paused && words_sent >= TARGET_WORDS / 2) begin
        paused = 1'b1;
        await_all_answers();
      end
      if ($urandom_range(0, 4) == 0) begin
        send_word(spte_pkg::CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                  $urandom_range(0, 31), $urandom_range(0, 15), 1'($urandom_range(0, 1)));
      end else begin
        // Load a patch around the center, drop grains into it, then look at the result.
        reach = $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) begin
          send_word(spte_pkg::CMD_WRITE, CENTER, CENTER, $urandom_range(0, 8),
                    $urandom_range(0, 5) == 0);
        end
        repeat ($urandom_range(2, 6)) begin
          send_word(spte_pkg::CMD_WRITE, near_center(reach), near_center(reach),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8),
                    $urandom_range(0, 9) == 0);
        end
        repeat ($urandom_range(1, 4)) begin
          send_word(spte_pkg::CMD_DROP, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 15), 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(1, 3)) begin
          send_word(spte_pkg::CMD_READ, near_center(reach + 1), near_center(reach + 1),
                    $urandom_range(0, 15), 1'($urandom_range(0, 1)));
        end
      end
    end

    await_all_answers();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/spte_pkg.sv
hdl/spte_ifs.sv
hdl/spte_grid_ram.sv
hdl/spte_fifo.sv
hdl/spte_ctrl.sv
hdl/sandpile_topple_engine.sv
tb/sv/sandpile_topple_engine_chk.sv
tb/sv/sandpile_topple_engine_tb.sv
